// File: rtl/core/ltrk_pkg.sv
// Shared types and constants of the two-axis light tracker stepper.
// Used by the front classifier, the item queue, the back sequencer and the top level.
// No dependencies.
package ltrk_pkg;

    // Field widths
    localparam int LIGHT_BITS    = 16;
    localparam int THR_BITS      = 16;
    localparam int LIM_BITS      = 17;
    localparam int POS_BITS      = 18;
    localparam int OUT_POS_BITS  = 18;
    localparam int PHASE_BITS    = 4;
    localparam int MODE_BITS     = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 17;
    localparam int TDATA_IN_BITS  = 48;
    localparam int TDATA_OUT_BITS = 48;

    // Positions compare against the limits at a width that holds both signed
    localparam int CMP_BITS = (POS_BITS > LIM_BITS + 1) ? POS_BITS : LIM_BITS + 1;

    // Compensation pattern: polar steps at phase 0 or 5 of a nine-step cycle
    localparam logic [PHASE_BITS-1:0] PHASE_FIRST = 4'd0;
    localparam logic [PHASE_BITS-1:0] PHASE_COMP  = 4'd5;
    localparam logic [PHASE_BITS-1:0] PHASE_LAST  = 4'd8;

    // Register reset values
    localparam logic [THR_BITS-1:0] MOVE_THR_RST   = 16'd10;
    localparam logic [THR_BITS-1:0] SETTLE_THR_RST = 16'd1;
    localparam logic [THR_BITS-1:0] IRR_THR_RST    = 16'd1;
    localparam logic [LIM_BITS-1:0] AZ_LIM_RST     = 17'd56000;
    localparam logic [LIM_BITS-1:0] POL_LIM_RST    = 17'd38000;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MOVE_THR   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SETTLE_THR = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IRR_THR    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AZ_LIM     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POL_LIM    = 3'd4;

    // Reported mode codes
    localparam logic [MODE_BITS-1:0] MODE_CODE_DECIDE   = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_CODE_AZ_TRACK = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_CODE_POL_DOWN = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_CODE_POL_UP   = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_CODE_TURN     = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_CODE_HOME_POL = 3'd5;
    localparam logic [MODE_BITS-1:0] MODE_CODE_HOME_AZ  = 3'd6;

    // Sequencer modes, one-hot
    typedef enum logic [6:0] {
        M_DECIDE   = 7'b0000001,
        M_AZ_TRACK = 7'b0000010,
        M_POL_DOWN = 7'b0000100,
        M_POL_UP   = 7'b0001000,
        M_TURN     = 7'b0010000,
        M_HOME_POL = 7'b0100000,
        M_HOME_AZ  = 7'b1000000
    } t_mode;

    // Thresholds used by the classifier
    typedef struct packed {
        logic [THR_BITS-1:0] move_thr;
        logic [THR_BITS-1:0] settle_thr;
        logic [THR_BITS-1:0] irr_thr;
    } t_thr_cfg;

    // Light comparisons of one item, independent of sequencer state
    typedef struct packed {
        logic lr_mt;      // left - right > move threshold
        logic rl_mt;      // right - left > move threshold
        logic ul_mt;      // up - left > move threshold
        logic lu_mt;      // left - up > move threshold
        logic lr_st;      // left - right > settle threshold
        logic rl_st;      // right - left > settle threshold
        logic ul_st;      // up - left > settle threshold
        logic lu_st;      // left - up > settle threshold
        logic any_bright; // some reading above irradiance threshold
        logic up_dark;    // up below irradiance threshold
    } t_cls;

    // One result item
    typedef struct packed {
        logic                           low_light;
        logic                           pol_limit_hit;
        logic                           az_limit_hit;
        logic signed [OUT_POS_BITS-1:0] pol_pos;
        logic signed [OUT_POS_BITS-1:0] az_pos;
        logic [MODE_BITS-1:0]           mode_now;
        logic                           pol_dir;
        logic                           pol_step;
        logic                           az_dir;
        logic                           az_step;
    } t_res;

    // Map a one-hot mode to its reported code
    function automatic logic [MODE_BITS-1:0] mode_code(input t_mode m);
        logic [MODE_BITS-1:0] c;
        unique case (m)
            M_DECIDE:   c = MODE_CODE_DECIDE;
            M_AZ_TRACK: c = MODE_CODE_AZ_TRACK;
            M_POL_DOWN: c = MODE_CODE_POL_DOWN;
            M_POL_UP:   c = MODE_CODE_POL_UP;
            M_TURN:     c = MODE_CODE_TURN;
            M_HOME_POL: c = MODE_CODE_HOME_POL;
            M_HOME_AZ:  c = MODE_CODE_HOME_AZ;
            default:    c = MODE_CODE_DECIDE;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/ltrk_front.sv
// Front classifier: turns the three light readings of an item into compare flags.
// Depends on ltrk_pkg.
module ltrk_front
    import ltrk_pkg::*;
(
    input  logic [LIGHT_BITS-1:0] i_up,
    input  logic [LIGHT_BITS-1:0] i_left,
    input  logic [LIGHT_BITS-1:0] i_right,
    input  t_thr_cfg              i_thr,
    output t_cls                  o_cls
);

    logic signed [LIGHT_BITS+1:0] w_lr, w_rl, w_ul, w_lu;
    logic signed [LIGHT_BITS+1:0] w_mt, w_st;

    // Form signed differences and thresholds
    assign w_lr = signed'({2'b00, i_left})  - signed'({2'b00, i_right});
    assign w_rl = signed'({2'b00, i_right}) - signed'({2'b00, i_left});
    assign w_ul = signed'({2'b00, i_up})    - signed'({2'b00, i_left});
    assign w_lu = signed'({2'b00, i_left})  - signed'({2'b00, i_up});
    assign w_mt = signed'({2'b00, i_thr.move_thr});
    assign w_st = signed'({2'b00, i_thr.settle_thr});

    // Classify the item
    assign o_cls.lr_mt      = w_lr > w_mt;
    assign o_cls.rl_mt      = w_rl > w_mt;
    assign o_cls.ul_mt      = w_ul > w_mt;
    assign o_cls.lu_mt      = w_lu > w_mt;
    assign o_cls.lr_st      = w_lr > w_st;
    assign o_cls.rl_st      = w_rl > w_st;
    assign o_cls.ul_st      = w_ul > w_st;
    assign o_cls.lu_st      = w_lu > w_st;
    assign o_cls.any_bright = (i_up > i_thr.irr_thr) || (i_left > i_thr.irr_thr)
                              || (i_right > i_thr.irr_thr);
    assign o_cls.up_dark    = i_up < i_thr.irr_thr;

endmodule

// File: rtl/core/ltrk_queue.sv
// Two-entry queue of classified items between the front and the back.
// Depends on ltrk_pkg.
module ltrk_queue
    import ltrk_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    output logic o_full,
    output logic o_valid,
    output t_cls o_data,
    input  logic i_pop
);

    t_cls       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    logic       n_wptr, n_rptr;
    logic [1:0] n_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rptr];

    // Advance pointers and count
    always_comb begin
        n_wptr = i_push ? ~r_wptr : r_wptr;
        n_rptr = i_pop  ? ~r_rptr : r_rptr;
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// File: rtl/core/ltrk_back.sv
// Back sequencer: runs the mode machine, positions and flags one item per cycle while
// the output register is free or being taken, and holds the result in it. Depends on ltrk_pkg.
module ltrk_back
    import ltrk_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [LIM_BITS-1:0] i_az_lim,
    input  logic [LIM_BITS-1:0] i_pol_lim,
    input  logic                i_valid,
    input  t_cls                i_cls,
    output logic                o_pop,
    output logic                o_valid,
    output t_res                o_res,
    input  logic                i_ready
);

    t_mode                      r_mode, n_mode;
    logic                       r_dir, n_dir;
    logic [LIM_BITS-1:0]        r_trem, n_trem;
    logic [PHASE_BITS-1:0]      r_phase, n_phase;
    logic                       r_moved, n_moved;
    logic                       r_azf, n_azf;
    logic                       r_polf, n_polf;
    logic                       r_llf, n_llf;
    logic signed [POS_BITS-1:0] r_az, n_az;
    logic signed [POS_BITS-1:0] r_pol, n_pol;
    logic                       r_out_valid;
    t_res                       r_res, n_res;

    assign o_pop   = i_valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    // Work out one slot: decide when idle, then run the current mode
    always_comb begin
        logic                       started, done, az_go, az_d;
        logic                       s_pol, s_pold;
        t_mode                      st_mode;
        logic                       st_dir;
        logic [LIM_BITS-1:0]        st_len;
        logic signed [CMP_BITS-1:0] lim_x, plim_x, az_x, pol_x;

        n_mode  = r_mode;
        n_dir   = r_dir;
        n_trem  = r_trem;
        n_phase = r_phase;
        n_moved = r_moved;
        n_azf   = r_azf;
        n_polf  = r_polf;
        n_llf   = r_llf;
        n_az    = r_az;
        n_pol   = r_pol;
        started = 1'b0;
        done    = 1'b0;
        az_go   = 1'b0;
        az_d    = 1'b0;
        s_pol   = 1'b0;
        s_pold  = 1'b0;
        st_mode = M_DECIDE;
        st_dir  = 1'b0;
        st_len  = '0;
        lim_x   = signed'(CMP_BITS'(i_az_lim));
        plim_x  = signed'(CMP_BITS'(i_pol_lim));
        az_x    = CMP_BITS'(r_az);
        pol_x   = CMP_BITS'(r_pol);

        // Choose a move
        if (n_mode == M_DECIDE) begin
            if (n_llf) begin
                if (i_cls.any_bright) begin
                    n_llf = 1'b0;
                end else if (r_pol != '0) begin
                    started = 1'b1;
                    st_mode = M_HOME_POL;
                    done    = 1'b1;
                end else if (r_az != '0) begin
                    started = 1'b1;
                    st_mode = M_HOME_AZ;
                    st_dir  = r_az[POS_BITS-1];
                    done    = 1'b1;
                end else begin
                    n_azf  = 1'b0;
                    n_polf = 1'b0;
                end
            end
            if (!done) begin
                priority if (n_azf) begin
                    n_azf = 1'b0;
                    if (az_x == lim_x) begin
                        started = 1'b1;
                        st_mode = M_TURN;
                        st_len  = i_az_lim;
                    end else if (az_x == -lim_x) begin
                        started = 1'b1;
                        st_mode = M_TURN;
                        st_dir  = 1'b1;
                        st_len  = i_az_lim;
                    end
                end else if (i_cls.lr_mt) begin
                    started = 1'b1;
                    st_mode = M_AZ_TRACK;
                    st_dir  = 1'b1;
                end else if (i_cls.rl_mt) begin
                    started = 1'b1;
                    st_mode = M_AZ_TRACK;
                end else if (i_cls.ul_mt) begin
                    started = 1'b1;
                    if (!r_pol[POS_BITS-1]) begin
                        n_polf  = 1'b0;
                        st_mode = M_POL_DOWN;
                    end else begin
                        st_mode = M_TURN;
                        st_dir  = !(!r_az[POS_BITS-1] && (r_az != '0));
                        st_len  = i_az_lim >> 1;
                    end
                end else if (i_cls.lu_mt && (pol_x < plim_x)) begin
                    n_polf  = 1'b0;
                    started = 1'b1;
                    st_mode = M_POL_UP;
                    st_dir  = 1'b1;
                end else begin
                    if (i_cls.up_dark) begin
                        n_llf = 1'b1;
                    end
                end
            end
            if (started) begin
                n_mode  = st_mode;
                n_dir   = st_dir;
                n_trem  = st_len;
                n_phase = PHASE_FIRST;
                n_moved = 1'b0;
            end
        end

        // Run one step of the current mode
        unique case (n_mode)
            M_DECIDE: begin
            end
            M_AZ_TRACK: begin
                if (n_dir ? i_cls.lr_st : i_cls.rl_st) begin
                    az_go = 1'b1;
                    az_d  = n_dir;
                    n_az  = n_dir ? r_az + POS_BITS'(1) : r_az - POS_BITS'(1);
                    if (CMP_BITS'(n_az) == (n_dir ? lim_x : -lim_x)) begin
                        n_azf  = 1'b1;
                        n_mode = M_DECIDE;
                    end
                end else begin
                    n_mode = M_DECIDE;
                end
            end
            M_POL_DOWN: begin
                if (i_cls.ul_st) begin
                    s_pol = 1'b1;
                    n_pol = r_pol - POS_BITS'(1);
                    if (n_pol[POS_BITS-1] || (n_pol == '0)) begin
                        n_mode = M_DECIDE;
                    end
                end else begin
                    n_mode = M_DECIDE;
                end
            end
            M_POL_UP: begin
                if (i_cls.lu_st) begin
                    s_pol  = 1'b1;
                    s_pold = 1'b1;
                    n_pol  = r_pol + POS_BITS'(1);
                    if (CMP_BITS'(n_pol) == plim_x) begin
                        n_polf = 1'b1;
                        n_mode = M_DECIDE;
                    end
                end else begin
                    n_mode = M_DECIDE;
                end
            end
            M_TURN: begin
                if (n_trem == '0) begin
                    n_mode = M_DECIDE;
                end else begin
                    az_go  = 1'b1;
                    az_d   = n_dir;
                    n_az   = n_dir ? r_az + POS_BITS'(1) : r_az - POS_BITS'(1);
                    n_trem = n_trem - LIM_BITS'(1);
                    if (n_trem == '0) begin
                        n_mode = M_DECIDE;
                    end
                end
            end
            M_HOME_POL: begin
                if (r_pol[POS_BITS-1]) begin
                    s_pol  = 1'b1;
                    s_pold = 1'b1;
                    n_pol  = r_pol + POS_BITS'(1);
                end else if (r_pol != '0) begin
                    s_pol = 1'b1;
                    n_pol = r_pol - POS_BITS'(1);
                end
                if (n_pol == '0) begin
                    if (r_az != '0) begin
                        n_mode  = M_HOME_AZ;
                        n_dir   = r_az[POS_BITS-1];
                        n_trem  = '0;
                        n_phase = PHASE_FIRST;
                        n_moved = 1'b0;
                    end else begin
                        n_azf  = 1'b0;
                        n_polf = 1'b0;
                        n_mode = M_DECIDE;
                    end
                end
            end
            M_HOME_AZ: begin
                if (r_az != '0) begin
                    az_go = 1'b1;
                    az_d  = r_az[POS_BITS-1];
                    n_az  = az_d ? r_az + POS_BITS'(1) : r_az - POS_BITS'(1);
                end
                if (n_az == '0) begin
                    n_azf  = 1'b0;
                    n_polf = 1'b0;
                    n_mode = M_DECIDE;
                end
            end
            default: begin
                n_mode = M_DECIDE;
            end
        endcase

        // Apply the interleaved polar compensation of an azimuth step
        if (az_go) begin
            if (n_moved && ((n_phase == PHASE_FIRST) || (n_phase == PHASE_COMP))) begin
                s_pol  = 1'b1;
                s_pold = az_d;
            end
            n_phase = (n_phase >= PHASE_LAST) ? PHASE_FIRST : n_phase + PHASE_BITS'(1);
            n_moved = 1'b1;
        end

        n_res.az_step       = az_go;
        n_res.az_dir        = az_go && az_d;
        n_res.pol_step      = s_pol;
        n_res.pol_dir       = s_pol && s_pold;
        n_res.mode_now      = mode_code(n_mode);
        n_res.az_pos        = OUT_POS_BITS'(n_az);
        n_res.pol_pos       = OUT_POS_BITS'(n_pol);
        n_res.az_limit_hit  = n_azf;
        n_res.pol_limit_hit = n_polf;
        n_res.low_light     = n_llf;
    end

    // Commit state on each taken item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_DECIDE;
            r_dir       <= 1'b0;
            r_trem      <= '0;
            r_phase     <= PHASE_FIRST;
            r_moved     <= 1'b0;
            r_azf       <= 1'b0;
            r_polf      <= 1'b0;
            r_llf       <= 1'b0;
            r_az        <= '0;
            r_pol       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mode  <= n_mode;
                r_dir   <= n_dir;
                r_trem  <= n_trem;
                r_phase <= n_phase;
                r_moved <= n_moved;
                r_azf   <= n_azf;
                r_polf  <= n_polf;
                r_llf   <= n_llf;
                r_az    <= n_az;
                r_pol   <= n_pol;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

endmodule

// File: rtl/core/two_axis_light_tracker_stepper.sv
// Top level of the two-axis light tracker stepper: register bank and stream ports.
// Depends on ltrk_pkg, ltrk_front, ltrk_queue and ltrk_back.
//
// One item is one step slot carrying up, left and right light readings; each gives
// exactly one result with the azimuth and polar step pulses and directions, the mode,
// both positions and the three flags after the slot. The block takes one item per
// clock cycle while the result side does not stall; the per-slot state update in the back
// sequencer is one register stage, which sets that rate. An accepted item is registered
// in the two-entry item queue and then in the output register, which presents the result.
// Stalls on the result side fill the queue and then drop s_axis_tready.
// Registers are written through the plain write port; the user must write them only
// while no item is in flight, as the block itself does not enforce this.
module two_axis_light_tracker_stepper
    import ltrk_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_wdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // up_light[15:0], left_light[31:16], right_light[47:32]
    input  logic [TDATA_IN_BITS-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // azimuth_step[0], azimuth_dir[1], polar_step[2], polar_dir[3], mode_now[6:4],
    // azimuth_pos[24:7], polar_pos[42:25], azimuth_limit_hit[43],
    // polar_limit_hit[44], low_light[45], zero[47:46]
    output logic [TDATA_OUT_BITS-1:0] m_axis_tdata
);

    t_thr_cfg            r_thr;
    logic [LIM_BITS-1:0] r_az_lim, r_pol_lim;
    t_cls                w_cls, w_q_cls;
    logic                w_push, w_full, w_q_valid, w_pop;
    t_res                w_res;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.move_thr   <= MOVE_THR_RST;
            r_thr.settle_thr <= SETTLE_THR_RST;
            r_thr.irr_thr    <= IRR_THR_RST;
            r_az_lim         <= AZ_LIM_RST;
            r_pol_lim        <= POL_LIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MOVE_THR:   r_thr.move_thr   <= i_cfg_wdata[THR_BITS-1:0];
                CFG_SETTLE_THR: r_thr.settle_thr <= i_cfg_wdata[THR_BITS-1:0];
                CFG_IRR_THR:    r_thr.irr_thr    <= i_cfg_wdata[THR_BITS-1:0];
                CFG_AZ_LIM:     r_az_lim         <= i_cfg_wdata[LIM_BITS-1:0];
                CFG_POL_LIM:    r_pol_lim        <= i_cfg_wdata[LIM_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Classify incoming items
    ltrk_front u_front (
        .i_up    (s_axis_tdata[15:0]),
        .i_left  (s_axis_tdata[31:16]),
        .i_right (s_axis_tdata[47:32]),
        .i_thr   (r_thr),
        .o_cls   (w_cls)
    );

    assign s_axis_tready = !w_full;
    assign w_push        = s_axis_tvalid && !w_full;

    // Queue classified items
    ltrk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cls),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_cls),
        .i_pop   (w_pop)
    );

    // Run the step sequencer
    ltrk_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_az_lim  (r_az_lim),
        .i_pol_lim (r_pol_lim),
        .i_valid   (w_q_valid),
        .i_cls     (w_q_cls),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .o_res     (w_res),
        .i_ready   (m_axis_tready)
    );

    // Pack the result item
    assign m_axis_tdata = {2'b00, w_res};

endmodule

// File: dv/tb_two_axis_light_tracker_stepper.sv
// Testbench for two_axis_light_tracker_stepper: stream items of light readings in,
// step results out, checked against a slot-by-slot predictor kept in a scoreboard class.
// Depends on ltrk_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_two_axis_light_tracker_stepper;
    import ltrk_pkg::*;

    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 80;
    localparam int MAX_REPORTS   = 20;
    localparam int TIMEOUT_NS    = 4_000_000;

    typedef enum int {
        SC_LEFT, SC_RIGHT, SC_UP_OVER_LEFT, SC_LEFT_OVER_UP, SC_EVEN, SC_DARK, SC_NOISE
    } t_scene;

    // Predicts one result item per slot and checks arriving results in order
    class tracker_scoreboard;
        int move_thr, settle_thr, irr_thr, az_lim, pol_lim;
        logic [POS_BITS-1:0]   az_cnt, pol_cnt;
        logic [MODE_BITS-1:0]  mode;
        logic                  move_up;
        logic [LIM_BITS-1:0]   turn_left;
        logic [PHASE_BITS-1:0] phase;
        logic                  stepped;
        logic                  az_flag, pol_flag, dark_flag;
        t_res                  slot;
        t_res                  pending_slots[$];
        int                    mismatches, checked, az_steps, pol_steps, limit_events;
        bit [6:0]              modes_seen;

        function new();
            move_thr   = int'(MOVE_THR_RST);
            settle_thr = int'(SETTLE_THR_RST);
            irr_thr    = int'(IRR_THR_RST);
            az_lim     = int'(AZ_LIM_RST);
            pol_lim    = int'(POL_LIM_RST);
            az_cnt     = '0;
            pol_cnt    = '0;
            mode       = MODE_CODE_DECIDE;
            move_up    = 1'b0;
            turn_left  = '0;
            phase      = PHASE_FIRST;
            stepped    = 1'b0;
            az_flag    = 1'b0;
            pol_flag   = 1'b0;
            dark_flag  = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                CFG_MOVE_THR:   move_thr   = int'(val[THR_BITS-1:0]);
                CFG_SETTLE_THR: settle_thr = int'(val[THR_BITS-1:0]);
                CFG_IRR_THR:    irr_thr    = int'(val[THR_BITS-1:0]);
                CFG_AZ_LIM:     az_lim     = int'(val[LIM_BITS-1:0]);
                CFG_POL_LIM:    pol_lim    = int'(val[LIM_BITS-1:0]);
                default: ;
            endcase
        endfunction

        function int pos_val(logic [POS_BITS-1:0] v);
            return int'($signed(v));
        endfunction

        function void begin_move(logic [MODE_BITS-1:0] m, logic up, int len);
            mode      = m;
            move_up   = up;
            turn_left = LIM_BITS'(len);
            phase     = PHASE_FIRST;
            stepped   = 1'b0;
        endfunction

        // One azimuth step; the polar motor follows on a move step taken at phase 5, or at phase 0 after the first
        function void az_advance(logic up);
            slot.az_step = 1'b1;
            slot.az_dir  = up;
            if (stepped && (phase == PHASE_FIRST || phase == PHASE_COMP)) begin
                slot.pol_step = 1'b1;
                slot.pol_dir  = up;
            end
            phase   = (phase >= PHASE_LAST) ? PHASE_FIRST : phase + 1'b1;
            stepped = 1'b1;
            az_cnt  = up ? az_cnt + 1'b1 : az_cnt - 1'b1;
            az_steps++;
        endfunction

        function void pol_advance(logic up);
            slot.pol_step = 1'b1;
            slot.pol_dir  = up;
            pol_cnt = up ? pol_cnt + 1'b1 : pol_cnt - 1'b1;
            pol_steps++;
        endfunction

        // Pick the next move from the readings, highest priority first
        function void choose_move(int u, int l, int r);
            int a;
            a = pos_val(az_cnt);
            if (dark_flag) begin
                if (u > irr_thr || l > irr_thr || r > irr_thr) begin
                    dark_flag = 1'b0;
                end else begin
                    if (pos_val(pol_cnt) != 0) begin
                        begin_move(MODE_CODE_HOME_POL, 1'b0, 0);
                        return;
                    end
                    if (a != 0) begin
                        begin_move(MODE_CODE_HOME_AZ, a < 0, 0);
                        return;
                    end
                    az_flag  = 1'b0;
                    pol_flag = 1'b0;
                end
            end
            if (az_flag) begin
                az_flag = 1'b0;
                if (a == az_lim)
                    begin_move(MODE_CODE_TURN, 1'b0, az_lim);
                else if (a == -az_lim)
                    begin_move(MODE_CODE_TURN, 1'b1, az_lim);
                return;
            end
            if (l - r > move_thr) begin
                begin_move(MODE_CODE_AZ_TRACK, 1'b1, 0);
                return;
            end
            if (r - l > move_thr) begin
                begin_move(MODE_CODE_AZ_TRACK, 1'b0, 0);
                return;
            end
            if (u - l > move_thr) begin
                if (pos_val(pol_cnt) >= 0) begin
                    pol_flag = 1'b0;
                    begin_move(MODE_CODE_POL_DOWN, 1'b0, 0);
                end else begin
                    // half turn back toward the centre
                    begin_move(MODE_CODE_TURN, !(a > 0), az_lim >> 1);
                end
                return;
            end
            if (l - u > move_thr && pos_val(pol_cnt) < pol_lim) begin
                pol_flag = 1'b0;
                begin_move(MODE_CODE_POL_UP, 1'b1, 0);
                return;
            end
            if (u < irr_thr)
                dark_flag = 1'b1;
        endfunction

        // Advance the running move by one slot
        function void run_move(int u, int l, int r);
            int d;
            int a;
            int p;
            case (mode)
                MODE_CODE_AZ_TRACK: begin
                    d = move_up ? l - r : r - l;
                    if (d > settle_thr) begin
                        az_advance(move_up);
                        if (pos_val(az_cnt) == (move_up ? az_lim : -az_lim)) begin
                            az_flag = 1'b1;
                            mode    = MODE_CODE_DECIDE;
                            limit_events++;
                        end
                    end else begin
                        mode = MODE_CODE_DECIDE;
                    end
                end
                MODE_CODE_POL_DOWN: begin
                    if (u - l > settle_thr) begin
                        pol_advance(1'b0);
                        if (pos_val(pol_cnt) <= 0)
                            mode = MODE_CODE_DECIDE;
                    end else begin
                        mode = MODE_CODE_DECIDE;
                    end
                end
                MODE_CODE_POL_UP: begin
                    if (l - u > settle_thr) begin
                        pol_advance(1'b1);
                        if (pos_val(pol_cnt) == pol_lim) begin
                            pol_flag = 1'b1;
                            mode     = MODE_CODE_DECIDE;
                            limit_events++;
                        end
                    end else begin
                        mode = MODE_CODE_DECIDE;
                    end
                end
                MODE_CODE_TURN: begin
                    if (turn_left == 0) begin
                        mode = MODE_CODE_DECIDE;
                    end else begin
                        az_advance(move_up);
                        turn_left = turn_left - 1'b1;
                        if (turn_left == 0)
                            mode = MODE_CODE_DECIDE;
                    end
                end
                MODE_CODE_HOME_POL: begin
                    p = pos_val(pol_cnt);
                    if (p < 0)
                        pol_advance(1'b1);
                    else if (p > 0)
                        pol_advance(1'b0);
                    if (pos_val(pol_cnt) == 0) begin
                        a = pos_val(az_cnt);
                        if (a != 0) begin
                            begin_move(MODE_CODE_HOME_AZ, a < 0, 0);
                        end else begin
                            az_flag  = 1'b0;
                            pol_flag = 1'b0;
                            mode     = MODE_CODE_DECIDE;
                        end
                    end
                end
                MODE_CODE_HOME_AZ: begin
                    a = pos_val(az_cnt);
                    if (a != 0)
                        az_advance(a < 0);
                    if (pos_val(az_cnt) == 0) begin
                        az_flag  = 1'b0;
                        pol_flag = 1'b0;
                        mode     = MODE_CODE_DECIDE;
                    end
                end
                default: mode = MODE_CODE_DECIDE;
            endcase
        endfunction

        // Work out the result of one accepted slot and queue it
        function void note_slot(input logic [15:0] up_l, left_l, right_l);
            int u;
            int l;
            int r;
            u = int'(up_l);
            l = int'(left_l);
            r = int'(right_l);
            slot = '0;
            if (mode == MODE_CODE_DECIDE || mode > MODE_CODE_HOME_AZ) begin
                mode = MODE_CODE_DECIDE;
                choose_move(u, l, r);
            end
            if (mode != MODE_CODE_DECIDE)
                run_move(u, l, r);
            slot.mode_now      = mode;
            slot.az_pos        = az_cnt;
            slot.pol_pos       = pol_cnt;
            slot.az_limit_hit  = az_flag;
            slot.pol_limit_hit = pol_flag;
            slot.low_light     = dark_flag;
            modes_seen[mode]   = 1'b1;
            pending_slots.push_back(slot);
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] result %0d: %s", $time, checked, what);
        endtask

        task match_field(string name, logic [17:0] got, logic [17:0] want);
            if (got !== want)
                report($sformatf("%s got %0h, predicted %0h", name, got, want));
        endtask

        task check_result(logic [TDATA_OUT_BITS-1:0] word);
            t_res got;
            t_res want;
            if (pending_slots.size() == 0) begin
                report("result arrived with no slot outstanding");
                return;
            end
            want = pending_slots.pop_front();
            got  = word[$bits(t_res)-1:0];
            match_field("azimuth_step", got.az_step, want.az_step);
            match_field("azimuth_dir", got.az_dir, want.az_dir);
            match_field("polar_step", got.pol_step, want.pol_step);
            match_field("polar_dir", got.pol_dir, want.pol_dir);
            match_field("mode_now", got.mode_now, want.mode_now);
            match_field("azimuth_pos", got.az_pos, want.az_pos);
            match_field("polar_pos", got.pol_pos, want.pol_pos);
            match_field("azimuth_limit_hit", got.az_limit_hit, want.az_limit_hit);
            match_field("polar_limit_hit", got.pol_limit_hit, want.pol_limit_hit);
            match_field("low_light", got.low_light, want.low_light);
            match_field("padding", word[TDATA_OUT_BITS-1:$bits(t_res)], '0);
            checked++;
        endtask
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_wdata = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // up_light[15:0], left_light[31:16], right_light[47:32]
    logic [TDATA_IN_BITS-1:0]  s_axis_tdata = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // azimuth_step[0], azimuth_dir[1], polar_step[2], polar_dir[3], mode_now[6:4],
    // azimuth_pos[24:7], polar_pos[42:25], azimuth_limit_hit[43],
    // polar_limit_hit[44], low_light[45], zero[47:46]
    logic [TDATA_OUT_BITS-1:0] m_axis_tdata;

    tracker_scoreboard sb = new();
    bit no_idle = 1'b0;
    bit hold_results = 1'b0;
    int items_sent = 0;
    int settings_loaded = 1;

    two_axis_light_tracker_stepper dut (.*);

    always #2 i_clk = ~i_clk;

    // Gap length for either side: mostly none or short, now and then long
    function automatic int idle_gap();
        int pick;
        if (no_idle)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int clip16(int v);
        return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic send_slot(input logic [15:0] up_l, left_l, right_l);
        int span;
        span = idle_gap();
        if (span > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (span) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right_l, left_l, up_l};
        @(negedge i_clk);
        while (s_axis_tready !== 1'b1)
            @(negedge i_clk);
        @(posedge i_clk);
        sb.note_slot(up_l, left_l, right_l);
        items_sent++;
    endtask

    // Hold off until every predicted result has come, then let the pipe settle
    task automatic wait_drain();
        while (sb.pending_slots.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_settings(input int mt, input int st, input int irr,
                                 input int azl, input int pll);
        logic [CFG_IDX_BITS-1:0]  reg_idx [5];
        logic [CFG_DATA_BITS-1:0] reg_val [5];
        reg_idx = '{CFG_MOVE_THR, CFG_SETTLE_THR, CFG_IRR_THR, CFG_AZ_LIM, CFG_POL_LIM};
        reg_val = '{CFG_DATA_BITS'(mt), CFG_DATA_BITS'(st), CFG_DATA_BITS'(irr),
                    CFG_DATA_BITS'(azl), CFG_DATA_BITS'(pll)};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= reg_idx[k];
            i_cfg_wdata <= reg_val[k];
            sb.set_reg(reg_idx[k], reg_val[k]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // Runs of one lighting scene with random levels; squeeze stalls the results early on
    task automatic run_scenes(input int n_items, input bit squeeze);
        t_scene scene;
        int pick, run, cap, done, hi, lo, t, noise, jit;
        int u, l, r;
        done = 0;
        no_idle = squeeze;
        hold_results = squeeze;
        while (done < n_items) begin
            pick = $urandom_range(0, 99);
            scene = (pick < 20) ? SC_LEFT : (pick < 40) ? SC_RIGHT :
                    (pick < 55) ? SC_UP_OVER_LEFT : (pick < 70) ? SC_LEFT_OVER_UP :
                    (pick < 80) ? SC_EVEN : (pick < 90) ? SC_DARK : SC_NOISE;
            cap = ((sb.az_lim < 40) ? sb.az_lim : 40) * 2 + 4;
            run = (scene == SC_NOISE) ? $urandom_range(1, 3) : $urandom_range(1, cap);
            for (int k = 0; k < run && done < n_items; k++) begin
                hi = $urandom_range(0, 65535);
                lo = $urandom_range(0, 65535);
                // now and then land near the move threshold
                if ($urandom_range(0, 3) == 0)
                    hi = clip16(lo + $urandom_range(0, 2 * sb.move_thr + 4));
                if (hi < lo) begin
                    t  = hi;
                    hi = lo;
                    lo = t;
                end
                noise = $urandom_range(0, 65535);
                jit   = $urandom_range(0, sb.settle_thr + 1);
                case (scene)
                    SC_LEFT:         begin u = noise; l = hi; r = lo; end
                    SC_RIGHT:        begin u = noise; l = lo; r = hi; end
                    SC_UP_OVER_LEFT: begin u = hi; l = lo; r = lo; end
                    SC_LEFT_OVER_UP: begin u = lo; l = hi; r = hi; end
                    SC_EVEN: begin
                        u = clip16(hi - jit);
                        l = hi;
                        r = clip16(hi + jit);
                    end
                    SC_DARK: begin
                        u = $urandom_range(0, sb.irr_thr);
                        l = $urandom_range(0, sb.irr_thr);
                        r = $urandom_range(0, sb.irr_thr);
                    end
                    default: begin
                        u = noise;
                        l = $urandom_range(0, 65535);
                        r = $urandom_range(0, 65535);
                    end
                endcase
                send_slot(16'(u), 16'(l), 16'(r));
                done++;
            end
            // keep the back-to-back stretch going until the receiver has stalled a while
            no_idle = (squeeze && done < 60) || ($urandom_range(0, 99) < 15);
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;
    endtask

    // Receiver: random ready pattern, with one long hold-off on request
    initial begin
        int span;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_results) begin
                hold_results = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else begin
                span = idle_gap();
                if (span > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (span - 1) @(posedge i_clk);
                end else begin
                    m_axis_tready <= 1'b1;
                    repeat ($urandom_range(0, 11)) @(posedge i_clk);
                end
            end
        end
    end

    // Check each result item on the falling clock edge while it is offered with ready high
    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed slots on reset settings: darkness, full light, both tracking
        // directions with compensation steps on the leftward run, polar down below zero and back up
        send_slot(16'h0000, 16'h0000, 16'h0000);
        send_slot(16'h0000, 16'h0000, 16'h0000);
        send_slot(16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (10) send_slot(16'h0000, 16'hFFFF, 16'h0000);
        send_slot(16'h0000, 16'h0000, 16'h0000);
        send_slot(16'h0000, 16'h0000, 16'hFFFF);
        send_slot(16'hFFFF, 16'h0000, 16'h0000);
        send_slot(16'hFFFF, 16'h0000, 16'h0000);
        send_slot(16'h0000, 16'hFFFF, 16'hFFFF);
        send_slot(16'h0000, 16'hFFFF, 16'hFFFF);
        send_slot(16'h0001, 16'h0001, 16'h0001);
        send_slot(16'h0000, 16'h0000, 16'h0000);
        s_axis_tvalid <= 1'b0;
        wait_drain();

        // Small limits so that limit stops, reversals and homing come often
        load_settings(10, 1, 40, 12, 6);
        run_scenes(300, 1'b1);
        wait_drain();

        // Lowest settings: zero-length half turns, one-step reversals
        load_settings(0, 0, 0, 1, 1);
        run_scenes(250, 1'b0);
        wait_drain();

        // Highest settings: no move can start, low light sets in and homing runs
        load_settings(65535, 65535, 65535, 131071, 131071);
        run_scenes(150, 1'b0);

        for (int k = 0; k < 2; k++) begin
            wait_drain();
            load_settings($urandom_range(0, 300), $urandom_range(0, 40),
                          $urandom_range(0, 4000), $urandom_range(1, 40),
                          $urandom_range(1, 25));
            run_scenes(350, k == 0);
        end
        wait_drain();

        $display("Run covered %0d slots over %0d register settings: %0d azimuth and %0d polar steps",
                 items_sent, settings_loaded, sb.az_steps, sb.pol_steps);
        $display("Mode codes seen %b, limit stops %0d, results checked %0d",
                 sb.modes_seen, sb.limit_events, sb.checked);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog against a stalled handshake or a missing result
    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d results outstanding", sb.pending_slots.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/ltrk_pkg.sv
rtl/core/ltrk_front.sv
rtl/core/ltrk_queue.sv
rtl/core/ltrk_back.sv
rtl/core/two_axis_light_tracker_stepper.sv
dv/tb_two_axis_light_tracker_stepper.sv
